// File: sv/mbe_pkg.sv
// Shared constants for the Mandelbrot escape-time block.
`timescale 1ns / 1ps
package mbe_pkg;

  localparam int WORD_W            = 32;
  localparam int CNT_W             = 16;
  localparam int FRAC_BITS_DEFAULT = 28;
  localparam logic [CNT_W-1:0] MAX_ITERS_RESET = 16'd320;

endpackage

// File: sv/mandelbrot_escape_time.sv
// Escape-time counter for one complex point, one shared multiplier under a small sequencer.
`timescale 1ns / 1ps
// Usage:
//   Raise start with c_real and c_imag (signed, FRAC_BITS fraction bits) while busy is low;
//   that beat is taken at the clock edge. busy stays high while the point is worked on.
//   The answer appears on escape_count for exactly one cycle with done high; the receiver
//   cannot hold it off, and a new start may be given in that same cycle.
//   The iteration limit max_iters is written through cfg_valid/cfg_ready/cfg_data while
//   the block is idle; cfg_ready is low while busy.
// Sequence:
//   Each iteration steps through MUL_RR, MUL_II, MUL_RI and UPDATE: the single 32x32
//   multiplier forms zr*zr, zi*zi and zr*zi one after another, and UPDATE adds, saturates
//   and tests the result. A point that never escapes answers max_iters (320 at reset).
//   With a limit of 0 or 1 the answer 1 appears in the cycle after start.
// Reset:
//   Synchronous, active high: returns to idle, drops done and sets max_iters to 320.
module mandelbrot_escape_time
  import mbe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [WORD_W-1:0] c_real,
  input  logic signed [WORD_W-1:0] c_imag,
  output logic                     done,
  output logic [CNT_W-1:0]         escape_count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_data
);

  // Width of a product after the floor shift, and of the update sums.
  localparam int SW = 2 * WORD_W - FRAC_BITS;
  localparam int EW = ((SW > WORD_W) ? SW : WORD_W) + 2;
  localparam logic [2*WORD_W-1:0] ESC_LIM = 64'd4 << FRAC_BITS;
  localparam logic signed [EW-1:0] WORD_HI = EW'(32'sh7FFF_FFFF);
  localparam logic signed [EW-1:0] WORD_LO = EW'(32'sh8000_0000);

  typedef enum logic [2:0] {
    IDLE,
    MUL_RR,
    MUL_II,
    MUL_RI,
    UPDATE
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          max_iters;
  logic [CNT_W-1:0]          cnt;
  logic signed [WORD_W-1:0]  cr;
  logic signed [WORD_W-1:0]  ci;
  logic signed [WORD_W-1:0]  zr;
  logic signed [WORD_W-1:0]  zi;
  logic signed [2*WORD_W-1:0] prod;
  logic signed [SW-1:0]      rr;
  logic signed [SW-1:0]      ii;

  logic signed [WORD_W-1:0]   mul_a;
  logic signed [WORD_W-1:0]   mul_b;
  logic signed [2*WORD_W-1:0] prod_next;
  logic signed [SW-1:0]       prod_fs;
  logic signed [EW-1:0]       sum_r;
  logic signed [EW-1:0]       sum_i;
  logic signed [WORD_W-1:0]   zr_next;
  logic signed [WORD_W-1:0]   zi_next;
  logic [SW:0]                mag;
  logic                       escape;
  logic [CNT_W-1:0]           cnt_inc;
  logic                       limit_hit;

  assign busy      = (state != IDLE);
  assign cfg_ready = ~busy;

  // The one multiplier: zr*zr, then zi*zi, then zr*zi.
  always_comb begin
    mul_a     = (state == MUL_II) ? zi : zr;
    mul_b     = (state == MUL_RR) ? zr : zi;
    prod_next = mul_a * mul_b;
    // Arithmetic shift right rounds toward minus infinity.
    prod_fs   = prod[2*WORD_W-1:FRAC_BITS];
  end

  always_comb begin
    sum_r = EW'(rr) - EW'(ii) + EW'(cr);
    sum_i = (EW'(prod_fs) <<< 1) + EW'(ci);
    if (sum_r > WORD_HI) begin
      zr_next = WORD_HI[WORD_W-1:0];
    end else if (sum_r < WORD_LO) begin
      zr_next = WORD_LO[WORD_W-1:0];
    end else begin
      zr_next = sum_r[WORD_W-1:0];
    end
    if (sum_i > WORD_HI) begin
      zi_next = WORD_HI[WORD_W-1:0];
    end else if (sum_i < WORD_LO) begin
      zi_next = WORD_LO[WORD_W-1:0];
    end else begin
      zi_next = sum_i[WORD_W-1:0];
    end
    // Squares of a product are never negative, so the sum is taken unsigned.
    mag       = {1'b0, rr} + {1'b0, ii};
    escape    = (2*WORD_W)'(mag) > ESC_LIM;
    cnt_inc   = cnt + 1'b1;
    limit_hit = (cnt_inc >= max_iters);
  end

  // The squares rr and ii of the current iterate serve both as the escape test of the
  // previous iteration and as the inputs of the next one. cnt is zero for the start
  // point, which is not tested.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      done         <= 1'b0;
      max_iters    <= MAX_ITERS_RESET;
      escape_count <= '0;
      cnt          <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        max_iters <= cfg_data;
      end
      case (state)
        IDLE: begin
          if (start) begin
            cr  <= c_real;
            ci  <= c_imag;
            zr  <= c_real;
            zi  <= c_imag;
            cnt <= '0;
            if (max_iters <= CNT_W'(1)) begin
              done         <= 1'b1;
              escape_count <= CNT_W'(1);
            end else begin
              state <= MUL_RR;
            end
          end
        end
        MUL_RR: begin
          prod  <= prod_next;
          state <= MUL_II;
        end
        MUL_II: begin
          rr    <= prod_fs;
          prod  <= prod_next;
          state <= MUL_RI;
        end
        MUL_RI: begin
          ii    <= prod_fs;
          prod  <= prod_next;
          state <= UPDATE;
        end
        UPDATE: begin
          if ((cnt != '0) && escape) begin
            done         <= 1'b1;
            escape_count <= cnt;
            state        <= IDLE;
          end else if (limit_hit) begin
            done         <= 1'b1;
            escape_count <= cnt_inc;
            state        <= IDLE;
          end else begin
            zr    <= zr_next;
            zi    <= zi_next;
            cnt   <= cnt_inc;
            state <= MUL_RR;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/mbe_checker.sv
// Port-level checks for the escape-time block, bound to the top level.
`timescale 1ns / 1ps
module mbe_checker
  import mbe_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [CNT_W-1:0] escape_count
);

  // A result beat always comes with the block idle again.
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  // Every count is at least one.
  a_count_nonzero : assert property (@(posedge clk) disable iff (rst)
    done |-> (escape_count != '0))
    else $error("escape_count is zero");

  // An accepted start either begins work or answers at once.
  a_start_acts : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("start accepted but nothing followed");

  // The block only leaves its busy phase by delivering a result.
  a_busy_ends_done : assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("busy dropped without a result");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .escape_count(escape_count)
);
